// ===== rtl/tricorn_escape_time_iterator_assert.svh =====
// Assertion macros for the tricorn escape-time iterator.
`ifndef TRICORN_ESCAPE_TIME_ITERATOR_ASSERT_SVH
`define TRICORN_ESCAPE_TIME_ITERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define TEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TEC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tec_pkg.sv =====
// Types, constants and helpers shared by the tricorn iterator modules.
`timescale 1ns / 1ps
package tec_pkg;
   localparam int FRAC_BITS  = 26;
   localparam int ITER_WIDTH = 16;
   localparam int CELLS      = 2;

   localparam logic [3:0] CSR_MAX_ITER = 4'd0;
   localparam logic [3:0] CSR_ESC_MODE = 4'd1;

   localparam logic [1:0] MODE_SUM  = 2'd0;
   localparam logic [1:0] MODE_DIFF = 2'd1;
   localparam logic [1:0] MODE_PROD = 2'd2;

   localparam logic [127:0] THR_SQ   = 128'(1) << (2 * FRAC_BITS + 2);
   localparam logic [127:0] THR_PROD = 128'(1) << (2 * FRAC_BITS + 1);
   localparam logic [23:0]  ITER_CAP = 24'((32'd1 << ITER_WIDTH) - 32'd1);

   typedef struct packed {
      logic                    done;
      logic                    escaped;
      logic [ITER_WIDTH-1:0]   count;
      logic signed [31:0]      re;
      logic signed [31:0]      im;
      logic signed [31:0]      cr;
      logic signed [31:0]      ci;
   } token_type;

   typedef struct packed {
      logic [ITER_WIDTH-1:0] limit;
      logic [1:0]            mode;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// ===== rtl/tec_cell.sv =====
// One iteration cell: squares and cross product, then escape test and update.
`timescale 1ns / 1ps
module tec_cell (
   input  logic               clock,
   input  logic               reset,
   input  tec_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  tec_pkg::token_type in_tok,
   output logic               out_valid,
   output tec_pkg::token_type out_tok
);
   logic               s1_valid_ff;
   tec_pkg::token_type s1_tok_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff;
   logic signed [63:0] p_rr_in, p_ii_in, p_ri_in;
   logic               out_valid_ff;
   tec_pkg::token_type out_tok_ff, out_tok_in;

   logic [63:0]        ar2, ai2, ari;
   logic [64:0]        sq_sum;
   logic               esc;
   logic signed [63:0] diff, negp;
   logic signed [65:0] nre_w, nim_w;

   assign p_rr_in = in_tok.re * in_tok.re;
   assign p_ii_in = in_tok.im * in_tok.im;
   assign p_ri_in = in_tok.re * in_tok.im;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
      s1_tok_ff  <= in_tok;
      p_rr_ff    <= p_rr_in;
      p_ii_ff    <= p_ii_in;
      p_ri_ff    <= p_ri_in;
      out_tok_ff <= out_tok_in;
   end

   always_comb begin
      ar2    = p_rr_ff;
      ai2    = p_ii_ff;
      ari    = p_ri_ff[63] ? 64'(-p_ri_ff) : 64'(p_ri_ff);
      sq_sum = 65'(ar2) + 65'(ai2);
      case (cfg.mode)
         tec_pkg::MODE_DIFF: esc = (ar2 > ai2) && (128'(ar2 - ai2) > tec_pkg::THR_SQ);
         tec_pkg::MODE_PROD: esc = 128'(ari) > tec_pkg::THR_PROD;
         default:            esc = 128'(sq_sum) > tec_pkg::THR_SQ;
      endcase
      diff  = p_rr_ff - p_ii_ff;
      negp  = -p_ri_ff;
      nre_w = 66'(diff >>> tec_pkg::FRAC_BITS) + 66'(s1_tok_ff.cr);
      nim_w = 66'(negp >>> (tec_pkg::FRAC_BITS - 1)) + 66'(s1_tok_ff.ci);

      out_tok_in = s1_tok_ff;
      if (!s1_tok_ff.done) begin
         if ((s1_tok_ff.count != '0) && esc) begin
            out_tok_in.done    = 1'b1;
            out_tok_in.escaped = 1'b1;
            out_tok_in.count   = s1_tok_ff.count - tec_pkg::ITER_WIDTH'(1);
         end else if (s1_tok_ff.count == cfg.limit) begin
            out_tok_in.done    = 1'b1;
            out_tok_in.escaped = 1'b0;
         end else begin
            out_tok_in.re    = tec_pkg::sat32(nre_w);
            out_tok_in.im    = tec_pkg::sat32(nim_w);
            out_tok_in.count = s1_tok_ff.count + tec_pkg::ITER_WIDTH'(1);
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;
endmodule

// ===== rtl/tricorn_escape_time_iterator.sv =====
// Top level of the tricorn escape-time iterator: ring of iteration cells.
//
// Takes one point c (Q5.26 real and imaginary parts) and iterates
// z = conj(z)^2 + c from zero, testing for escape after each update, and
// returns escaped and the zero-based escape iteration (0 if bounded). One
// point is in flight at a time; it circulates through a ring of two
// iteration cells, each cell having two registers (product register,
// then update register). A point that runs n iterations makes n+1 passes
// (the last one only tests) and leaves the ring only after a whole trip
// round it. The default iteration limit is 64. While the output register
// still holds an unaccepted result, the finished point keeps circulating
// and is taken on the first ring trip that finds the register free. The
// next point is taken once the result has moved into the output register.
`timescale 1ns / 1ps
`include "tricorn_escape_time_iterator_assert.svh"
module tricorn_escape_time_iterator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // c_real[31:0], c_imag[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // escaped[0], escape_iteration[16:1], zero[23:17]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic [15:0] max_iter_ff;
   logic [1:0]  mode_ff;
   logic        busy_ff;
   logic        rsp_valid_ff;
   logic        rsp_escaped_ff;
   logic [15:0] rsp_iter_ff;

   tec_pkg::cfg_type   cfg;
   logic               link_valid [tec_pkg::CELLS+1];
   tec_pkg::token_type link_tok   [tec_pkg::CELLS+1];
   tec_pkg::token_type new_tok;
   logic               req_xfer, capture, recirc;
   logic [tec_pkg::CELLS-1:0] ring_valids;
   logic [23:0]        iter_wide;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      cfg.limit = (24'(max_iter_ff) > tec_pkg::ITER_CAP) ?
                  tec_pkg::ITER_WIDTH'(tec_pkg::ITER_CAP) :
                  tec_pkg::ITER_WIDTH'(max_iter_ff);
      cfg.mode  = mode_ff;
   end

   always_comb begin
      new_tok.done    = 1'b0;
      new_tok.escaped = 1'b0;
      new_tok.count   = '0;
      new_tok.re      = '0;
      new_tok.im      = '0;
      new_tok.cr      = req_tdata[31:0];
      new_tok.ci      = req_tdata[63:32];
   end

   assign capture = link_valid[tec_pkg::CELLS] && link_tok[tec_pkg::CELLS].done &&
                    (!rsp_valid_ff || rsp_tready);
   assign recirc  = link_valid[tec_pkg::CELLS] && !capture;

   assign link_valid[0] = req_xfer || recirc;
   assign link_tok[0]   = req_xfer ? new_tok : link_tok[tec_pkg::CELLS];

   for (genvar g = 0; g < tec_pkg::CELLS; g++) begin : g_cell
      tec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .in_valid  (link_valid[g]),
         .in_tok    (link_tok[g]),
         .out_valid (link_valid[g+1]),
         .out_tok   (link_tok[g+1])
      );
      assign ring_valids[g] = link_valid[g+1];
   end

   assign iter_wide = 24'(link_tok[tec_pkg::CELLS].count);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= 16'd64;
         mode_ff      <= tec_pkg::MODE_SUM;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tec_pkg::CSR_MAX_ITER: max_iter_ff <= csr_wdata;
               tec_pkg::CSR_ESC_MODE: mode_ff     <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_xfer) busy_ff <= 1'b1;
         else if (capture) busy_ff <= 1'b0;
         if (capture) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (capture) begin
         rsp_escaped_ff <= link_tok[tec_pkg::CELLS].escaped;
         rsp_iter_ff    <= link_tok[tec_pkg::CELLS].escaped ? iter_wide[15:0] : 16'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_iter_ff, rsp_escaped_ff};

   `TEC_ASSERT_NEXT(a_busy_after_req, req_xfer, busy_ff, "no busy after input transfer")
   `TEC_ASSERT_NEXT(a_capture_frees, capture, rsp_valid_ff && !busy_ff, "capture lost")
   `TEC_ASSERT_IMPLY(a_one_token, 1'b1, $countones(ring_valids) <= 1, "two tokens in ring")
   `TEC_ASSERT_IMPLY(a_idle_empty, !busy_ff, ring_valids == '0, "token while idle")
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the tricorn escape-time iterator.
`timescale 1ns / 1ps
module tb_top;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [3:0] CSR_UNUSED = 4'd7;
   localparam int         ONE        = 1 << 26;

   typedef struct packed {
      logic        escaped;
      logic [15:0] iter;
   } outcome_type;

   typedef struct {
      logic signed [31:0] cr;
      logic signed [31:0] ci;
      logic [15:0]        limit;
      logic [1:0]         mode;
      bit                 typed;
      outcome_type        want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   logic [15:0] cur_limit = 16'd64;
   logic [1:0]  cur_mode = tec_pkg::MODE_SUM;
   outcome_type pending[$];
   row_type     rows[$];
   int          errors = 0;
   int          n_points = 0;
   int          n_escaped = 0;
   bit          calm = 1'b0;

   tricorn_escape_time_iterator u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic bit over_threshold(longint re, longint im, logic [1:0] mode);
      longint unsigned ar, ai, r2, i2;
      ar = re < 0 ? -re : re;
      ai = im < 0 ? -im : im;
      r2 = ar * ar;
      i2 = ai * ai;
      if (mode == tec_pkg::MODE_DIFF) return r2 > i2 && (r2 - i2) > (64'd1 << 54);
      if (mode == tec_pkg::MODE_PROD) return (ar * ai) > (64'd1 << 53);
      return (r2 + i2) > (64'd1 << 54);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic outcome_type orbit_outcome(logic signed [31:0] cr,
                                                 logic signed [31:0] ci,
                                                 logic [15:0] limit, logic [1:0] mode);
      longint re, im, nre, nim;
      outcome_type o;
      re = 0;
      im = 0;
      o = '0;
      for (int i = 0; i < limit; i++) begin
         nre = clamp32(((re * re - im * im) >>> 26) + longint'(cr));
         nim = clamp32(((-(re * im)) >>> 25) + longint'(ci));
         re = nre;
         im = nim;
         if (over_threshold(re, im, mode)) begin
            o.escaped = 1'b1;
            o.iter = i[15:0];
            break;
         end
      end
      return o;
   endfunction

   task automatic write_reg(logic [3:0] idx, logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == tec_pkg::CSR_MAX_ITER) cur_limit = val;
      else if (idx == tec_pkg::CSR_ESC_MODE) cur_mode = val[1:0];
   endtask

   task automatic drain;
      while (pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_cfg(logic [15:0] limit, logic [1:0] mode);
      if (limit == cur_limit && mode == cur_mode) return;
      drain();
      write_reg(tec_pkg::CSR_MAX_ITER, limit);
      write_reg(tec_pkg::CSR_ESC_MODE, {14'd0, mode});
   endtask

   task automatic send_point(logic signed [31:0] cr, logic signed [31:0] ci,
                             bit typed, outcome_type want);
      while (!calm && $urandom_range(99) < 22) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {ci, cr};
      do @(posedge clock); while (!req_tready);
      pending.push_back(typed ? want : orbit_outcome(cr, ci, cur_limit, cur_mode));
      n_points++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   always @(negedge clock) rsp_tready <= calm || $urandom_range(99) >= 22;

   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            w = pending.pop_front();
            n_escaped += rsp_tdata[0];
            if (rsp_tdata[0] !== w.escaped) begin
               $display("%0t: escaped expected %0d actual %0d", $time, w.escaped, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[16:1] !== w.iter) begin
               $display("%0t: iteration expected %0d actual %0d", $time, w.iter,
                        rsp_tdata[16:1]);
               errors++;
            end
            if (rsp_tdata[23:17] !== 7'd0) begin
               $display("%0t: pad expected 0 actual %h", $time, rsp_tdata[23:17]);
               errors++;
            end
         end
      end
   end

   function automatic void add(int cr, int ci, int limit, logic [1:0] mode,
                               bit typed = 0, bit esc = 0, int it = 0);
      row_type r;
      r.cr = cr;
      r.ci = ci;
      r.limit = 16'(limit);
      r.mode = mode;
      r.typed = typed;
      r.want = {esc, 16'(it)};
      rows.push_back(r);
   endfunction

   initial begin
      logic signed [31:0] cr, ci;
      int span;
      add(0, 0, 64, tec_pkg::MODE_SUM, 1, 0, 0);
      add(32'h7fffffff, 32'h7fffffff, 64, tec_pkg::MODE_SUM, 1, 1, 0);
      add(32'h80000000, 32'h80000000, 64, tec_pkg::MODE_SUM, 1, 1, 0);
      add(32'h80000000, 32'h7fffffff, 64, tec_pkg::MODE_SUM, 1, 1, 0);
      add(-1, -1, 64, tec_pkg::MODE_SUM);
      add(-ONE / 4 * 3, ONE / 8, 64, tec_pkg::MODE_SUM);
      add(2 * ONE, 0, 1, tec_pkg::MODE_SUM, 1, 0, 0);
      add(2 * ONE + 1, 0, 1, tec_pkg::MODE_SUM, 1, 1, 0);
      add(32'h7fffffff, 32'h7fffffff, 0, tec_pkg::MODE_SUM, 1, 0, 0);
      add(32'h80000000, 0, 64, tec_pkg::MODE_DIFF, 1, 1, 0);
      add(0, 32'h7fffffff, 64, tec_pkg::MODE_DIFF);
      add(-ONE / 2, ONE / 2, 64, tec_pkg::MODE_DIFF);
      add(32'h7fffffff, 32'h7fffffff, 64, tec_pkg::MODE_PROD, 1, 1, 0);
      add(32'h7fffffff, 0, 64, tec_pkg::MODE_PROD);
      add(ONE / 3, -ONE, 64, tec_pkg::MODE_PROD);
      add(3 * ONE, ONE, 64, MODE_SPARE);
      add(-ONE / 10, ONE / 2, 64, MODE_SPARE);
      add(ONE / 4, ONE / 2, 2, tec_pkg::MODE_SUM);
      add(0, 0, 16'hffff, tec_pkg::MODE_SUM, 1, 0, 0);
      add(ONE / 4 + 5, 5, 16'hffff, tec_pkg::MODE_SUM);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (rows[k]) begin
         set_cfg(rows[k].limit, rows[k].mode);
         send_point(rows[k].cr, rows[k].ci, rows[k].typed, rows[k].want);
      end

      drain();
      write_reg(CSR_UNUSED, 16'h0003);
      write_reg(tec_pkg::CSR_ESC_MODE, 16'hfffe);
      send_point(32'h7fffffff, 32'h7fffffff, 1, {1'b1, 16'd0});
      send_point(ONE / 2, -ONE / 2, 0, '0);
      drain();
      write_reg(tec_pkg::CSR_ESC_MODE, 16'h0000);

      for (int n = 0; n < 1050; n++) begin
         calm = n >= 400 && n < 600;
         if (n % 50 == 0) begin
            case ($urandom_range(5))
               0: set_cfg(16'd0, 2'($urandom_range(3)));
               1: set_cfg(16'd1, 2'($urandom_range(3)));
               2: set_cfg(16'($urandom_range(300, 100)), 2'($urandom_range(3)));
               default: set_cfg(16'($urandom_range(80, 2)), 2'($urandom_range(3)));
            endcase
         end
         if ($urandom_range(3) == 0) begin
            cr = $urandom;
            ci = $urandom;
         end else begin
            span = $urandom_range(1) ? 5 * ONE / 2 : ONE / 2;
            cr = $urandom_range(2 * span) - span;
            ci = $urandom_range(2 * span) - span;
            if ($urandom_range(1)) cr = cr - ONE / 2;
         end
         send_point(cr, ci, 0, '0);
      end

      drain();
      repeat (300) @(negedge clock);
      $display("covered %0d points, %0d escaped; limits 0..65535, all four mode codes",
               n_points, n_escaped);
      if (errors == 0 && pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
